[rtl/core/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants and types of the cluster box filter: register indexes,
// reset values, reject codes and the scale factors of the density test.
// ----------------------------------------------------------------------------
package cbf_pkg;

    localparam int COORD_BITS_DEF = 16;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SIDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VOL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DENS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF  = 3'd4;

    localparam int SIDE_W  = 16;
    localparam int VOL_W   = 48;
    localparam int COUNT_W = 16;
    localparam int DENS_W  = 16;

    localparam logic [15:0]        RST_GROUND   = 16'd50;
    localparam logic [SIDE_W-1:0]  RST_MAX_SIDE = 16'd1500;
    localparam logic [VOL_W-1:0]   RST_MIN_VOL  = 48'd10000;
    localparam logic [DENS_W-1:0]  RST_MIN_DENS = 16'd1280;
    localparam logic [15:0]        RST_FALLOFF  = 16'd3277;

    // reject codes
    localparam int REASON_W = 3;
    localparam logic [REASON_W-1:0] REASON_KEEP   = 3'd0;
    localparam logic [REASON_W-1:0] REASON_GROUND = 3'd1;
    localparam logic [REASON_W-1:0] REASON_LARGE  = 3'd2;
    localparam logic [REASON_W-1:0] REASON_SMALL  = 3'd3;
    localparam logic [REASON_W-1:0] REASON_SPARSE = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // density test: count*10000*(13107200 + falloff*r2) < density*512*vol
    localparam int                   CNT_SCALED_W  = 30;
    localparam logic [13:0]          COUNT_SCALE   = 14'd10000;
    localparam logic [23:0]          RANGE_BASE    = 24'd13107200;
    localparam int                   DENS_SHIFT    = 9;
    localparam int                   DENS_SCALED_W = DENS_W + DENS_SHIFT;
    localparam int                   RHS_W         = VOL_W + DENS_SCALED_W;

    // cluster queue
    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = 1;
    localparam int Q_FILL_W = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[rtl/core/cbf_front.sv]
// ----------------------------------------------------------------------------
// cbf_front
// Point intake: keeps the running box and saturating count of the current
// cluster and pushes the finished box record on the last point.
// ----------------------------------------------------------------------------
module cbf_front #(
    parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [COORD_BITS-1:0]          px,
    input  logic signed [COORD_BITS-1:0]          py,
    input  logic signed [COORD_BITS-1:0]          pz,
    input  logic                                  last_point,
    input  cbf_pkg::q_status_t                    q_status,
    output logic                                  push,
    output logic [6*COORD_BITS+cbf_pkg::COUNT_W-1:0] push_data
);

    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic signed [COORD_BITS-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg, z_lo_reg, z_hi_reg;
    logic signed [COORD_BITS-1:0] x_lo_upd, x_hi_upd, y_lo_upd, y_hi_upd, z_lo_upd, z_hi_upd;
    logic [cbf_pkg::COUNT_W-1:0]  cnt_reg, cnt_upd;
    logic                         accept;

    assign in_stall = q_status.full;
    assign accept   = in_valid & ~q_status.full;

    assign x_lo_upd = (px < x_lo_reg) ? px : x_lo_reg;
    assign x_hi_upd = (px > x_hi_reg) ? px : x_hi_reg;
    assign y_lo_upd = (py < y_lo_reg) ? py : y_lo_reg;
    assign y_hi_upd = (py > y_hi_reg) ? py : y_hi_reg;
    assign z_lo_upd = (pz < z_lo_reg) ? pz : z_lo_reg;
    assign z_hi_upd = (pz > z_hi_reg) ? pz : z_hi_reg;
    assign cnt_upd  = (cnt_reg == cbf_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + 16'd1;

    assign push      = accept & last_point;
    assign push_data = {x_lo_upd, x_hi_upd, y_lo_upd, y_hi_upd, z_lo_upd, z_hi_upd, cnt_upd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_lo_reg <= C_MAX;
            x_hi_reg <= C_MIN;
            y_lo_reg <= C_MAX;
            y_hi_reg <= C_MIN;
            z_lo_reg <= C_MAX;
            z_hi_reg <= C_MIN;
            cnt_reg  <= '0;
        end
        else if (accept)
        begin
            if (last_point)
            begin
                // cluster closed: start the next one empty
                x_lo_reg <= C_MAX;
                x_hi_reg <= C_MIN;
                y_lo_reg <= C_MAX;
                y_hi_reg <= C_MIN;
                z_lo_reg <= C_MAX;
                z_hi_reg <= C_MIN;
                cnt_reg  <= '0;
            end
            else
            begin
                x_lo_reg <= x_lo_upd;
                x_hi_reg <= x_hi_upd;
                y_lo_reg <= y_lo_upd;
                y_hi_reg <= y_hi_upd;
                z_lo_reg <= z_lo_upd;
                z_hi_reg <= z_hi_upd;
                cnt_reg  <= cnt_upd;
            end
        end
    end

endmodule

[rtl/core/cbf_queue.sv]
// ----------------------------------------------------------------------------
// cbf_queue
// Two-entry queue of finished cluster boxes between intake and evaluation.
// ----------------------------------------------------------------------------
module cbf_queue #(
    parameter int W = 112
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [W-1:0]       push_data,
    input  logic               pop,
    output logic [W-1:0]       pop_data,
    output cbf_pkg::q_status_t q_status
);

    logic [W-1:0]                  mem_reg [cbf_pkg::Q_DEPTH];
    logic [cbf_pkg::Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [cbf_pkg::Q_FILL_W-1:0]  fill_reg, fill_next;

    assign q_status.full  = (fill_reg == cbf_pkg::Q_FILL_W'(cbf_pkg::Q_DEPTH));
    assign q_status.empty = (fill_reg == '0);
    assign pop_data       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("cluster queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("cluster queue read while empty");

endmodule

[rtl/core/cbf_mul.sv]
// ----------------------------------------------------------------------------
// cbf_mul
// Shift-and-add multiplier, one bit of b per cycle. done pulses for one
// cycle with the product valid; product holds until the next start.
// ----------------------------------------------------------------------------
module cbf_mul #(
    parameter int A_W = 48,
    parameter int B_W = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic               done,
    output logic [A_W+B_W-1:0] product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg, a_reg;
    logic [B_W-1:0]   b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= P_W'(a);
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

endmodule

[rtl/core/cbf_back.sv]
// ----------------------------------------------------------------------------
// cbf_back
// Cluster evaluation: runs the ground, size, volume and density tests on one
// box record with a shared serial multiplier and a digit-by-digit square
// root, then holds the result in an output register.
// ----------------------------------------------------------------------------
module cbf_back #(
    parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  cbf_pkg::q_status_t                       q_status,
    input  logic [6*COORD_BITS+cbf_pkg::COUNT_W-1:0] pop_data,
    output logic                                     pop,
    input  logic [15:0]                              ground_clearance_cm,
    input  logic [cbf_pkg::SIDE_W-1:0]               max_side_cm,
    input  logic [cbf_pkg::VOL_W-1:0]                min_volume_cm3,
    input  logic [cbf_pkg::DENS_W-1:0]               min_density_q8,
    input  logic [15:0]                              density_falloff_q16,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     keep,
    output logic [cbf_pkg::REASON_W-1:0]             reject_reason,
    output logic signed [COORD_BITS-1:0]             box_x_low,
    output logic signed [COORD_BITS-1:0]             box_x_high,
    output logic signed [COORD_BITS-1:0]             box_y_low,
    output logic signed [COORD_BITS-1:0]             box_y_high,
    output logic signed [COORD_BITS-1:0]             box_z_low,
    output logic signed [COORD_BITS-1:0]             box_z_high,
    output logic [cbf_pkg::COUNT_W-1:0]              point_total
);

    localparam int CB    = COORD_BITS;
    localparam int CW    = cbf_pkg::COUNT_W;
    localparam int EW    = (CB > 16) ? CB : 16;
    localparam int MAG_W = CB + 1;
    localparam int NW    = 2 * CB + 4;
    localparam int RW    = NW / 2;
    localparam int TW    = CB + 19;
    localparam int A_W   = (TW > cbf_pkg::VOL_W) ? TW : cbf_pkg::VOL_W;
    localparam int B_W   = (MAG_W > cbf_pkg::CNT_SCALED_W) ? MAG_W : cbf_pkg::CNT_SCALED_W;
    localparam int P_W   = A_W + B_W;
    localparam int LW    = TW + cbf_pkg::CNT_SCALED_W;
    localparam int CMP_W = (LW > cbf_pkg::RHS_W) ? LW : cbf_pkg::RHS_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_TEST = 4'd1;
    localparam logic [3:0] S_VOL1 = 4'd2;
    localparam logic [3:0] S_VOL2 = 4'd3;
    localparam logic [3:0] S_SQX  = 4'd4;
    localparam logic [3:0] S_SQY  = 4'd5;
    localparam logic [3:0] S_SQZ  = 4'd6;
    localparam logic [3:0] S_ROOT = 4'd7;
    localparam logic [3:0] S_FALL = 4'd8;
    localparam logic [3:0] S_CNT  = 4'd9;
    localparam logic [3:0] S_LHS  = 4'd10;
    localparam logic [3:0] S_RHS  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    logic [3:0] state_reg, state_next;

    // record fields
    logic signed [CB-1:0] rec_xl, rec_xh, rec_yl, rec_yh, rec_zl, rec_zh;
    logic [CW-1:0]        rec_cnt;

    logic signed [CB-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg, z_lo_reg, z_hi_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CB-1:0]        sx_reg, sy_reg, sz_reg;
    logic [MAG_W-1:0]     cx_reg, cy_reg, cz_reg;
    logic [cbf_pkg::VOL_W-1:0] vol_reg;
    logic [NW-1:0]        n_reg, op_reg, res_reg, one_reg;
    logic [TW-1:0]        t_reg;
    logic [LW-1:0]        lhs_reg;
    logic [cbf_pkg::REASON_W-1:0] reason_reg;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 keep_reg;
    logic [cbf_pkg::REASON_W-1:0] reason_out_reg;
    logic signed [CB-1:0] ox_lo_reg, ox_hi_reg, oy_lo_reg, oy_hi_reg, oz_lo_reg, oz_hi_reg;
    logic [CW-1:0]        total_reg;

    // multiplier
    logic                 mul_start, mul_done;
    logic [A_W-1:0]       mul_a;
    logic [B_W-1:0]       mul_b;
    logic [P_W-1:0]       mul_product;

    logic                 ground_fail, side_fail, vol_small, root_ge, sparse, load_out;
    logic [EW-1:0]        sxw, syw, szw, side_lim;
    logic [cbf_pkg::VOL_W-1:0] vol_raw, vol_fix;
    logic [NW-1:0]        trial;
    logic [TW-1:0]        t_sum;
    logic [cbf_pkg::DENS_SCALED_W-1:0] dens_scaled;

    function automatic logic [MAG_W-1:0] centre_mag(input logic signed [CB-1:0] lo,
                                                    input logic signed [CB-1:0] hi);
        logic signed [MAG_W-1:0] s;
        s = MAG_W'(lo) + MAG_W'(hi);
        centre_mag = s[MAG_W-1] ? MAG_W'(-s) : MAG_W'(s);
    endfunction

    assign rec_xl  = pop_data[6*CB+CW-1 -: CB];
    assign rec_xh  = pop_data[5*CB+CW-1 -: CB];
    assign rec_yl  = pop_data[4*CB+CW-1 -: CB];
    assign rec_yh  = pop_data[3*CB+CW-1 -: CB];
    assign rec_zl  = pop_data[2*CB+CW-1 -: CB];
    assign rec_zh  = pop_data[CB+CW-1 -: CB];
    assign rec_cnt = pop_data[CW-1:0];

    cbf_mul #(
        .A_W (A_W),
        .B_W (B_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign sxw      = EW'(sx_reg);
    assign syw      = EW'(sy_reg);
    assign szw      = EW'(sz_reg);
    assign side_lim = EW'(max_side_cm);

    assign ground_fail = $signed(EW'(z_lo_reg)) > $signed(EW'($signed(ground_clearance_cm)));
    assign side_fail   = (sxw > side_lim) || (syw > side_lim) || (szw > side_lim);

    // volume is raised to at least one cubic centimetre
    assign vol_raw   = mul_product[cbf_pkg::VOL_W-1:0];
    assign vol_fix   = (vol_raw == '0) ? cbf_pkg::VOL_W'(1) : vol_raw;
    assign vol_small = vol_fix < min_volume_cm3;

    assign trial   = res_reg + one_reg;
    assign root_ge = op_reg >= trial;

    assign t_sum       = TW'(cbf_pkg::RANGE_BASE) + mul_product[TW-1:0];
    assign dens_scaled = {min_density_q8, {cbf_pkg::DENS_SHIFT{1'b0}}};
    assign sparse      = CMP_W'(lhs_reg) < CMP_W'(mul_product[cbf_pkg::RHS_W-1:0]);

    assign pop = (state_reg == S_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (ground_fail || side_fail)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // sides are within the 16-bit limit from here on
                    mul_start  = 1'b1;
                    mul_a      = A_W'(sxw[cbf_pkg::SIDE_W-1:0]);
                    mul_b      = B_W'(syw[cbf_pkg::SIDE_W-1:0]);
                    state_next = S_VOL1;
                end
            end
            S_VOL1:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = A_W'(mul_product[2*cbf_pkg::SIDE_W-1:0]);
                    mul_b      = B_W'(szw[cbf_pkg::SIDE_W-1:0]);
                    state_next = S_VOL2;
                end
            end
            S_VOL2:
            begin
                if (mul_done)
                begin
                    if (vol_small)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        mul_a      = A_W'(cx_reg);
                        mul_b      = B_W'(cx_reg);
                        state_next = S_SQX;
                    end
                end
            end
            S_SQX:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = A_W'(cy_reg);
                    mul_b      = B_W'(cy_reg);
                    state_next = S_SQY;
                end
            end
            S_SQY:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = A_W'(cz_reg);
                    mul_b      = B_W'(cz_reg);
                    state_next = S_SQZ;
                end
            end
            S_SQZ:
            begin
                if (mul_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (one_reg == '0)
                begin
                    mul_start  = 1'b1;
                    mul_a      = A_W'(res_reg[RW-1:0]);
                    mul_b      = B_W'(density_falloff_q16);
                    state_next = S_FALL;
                end
            end
            S_FALL:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = A_W'(cnt_reg);
                    mul_b      = B_W'(cbf_pkg::COUNT_SCALE);
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = A_W'(t_reg);
                    mul_b      = B_W'(mul_product[cbf_pkg::CNT_SCALED_W-1:0]);
                    state_next = S_LHS;
                end
            end
            S_LHS:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = A_W'(vol_reg);
                    mul_b      = B_W'(dens_scaled);
                    state_next = S_RHS;
                end
            end
            S_RHS:
            begin
                if (mul_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    x_lo_reg   <= rec_xl;
                    x_hi_reg   <= rec_xh;
                    y_lo_reg   <= rec_yl;
                    y_hi_reg   <= rec_yh;
                    z_lo_reg   <= rec_zl;
                    z_hi_reg   <= rec_zh;
                    cnt_reg    <= rec_cnt;
                    sx_reg     <= CB'(rec_xh - rec_xl);
                    sy_reg     <= CB'(rec_yh - rec_yl);
                    sz_reg     <= CB'(rec_zh - rec_zl);
                    cx_reg     <= centre_mag(rec_xl, rec_xh);
                    cy_reg     <= centre_mag(rec_yl, rec_yh);
                    cz_reg     <= centre_mag(rec_zl, rec_zh);
                    reason_reg <= cbf_pkg::REASON_KEEP;
                end
            end
            S_TEST:
            begin
                if (ground_fail)
                begin
                    reason_reg <= cbf_pkg::REASON_GROUND;
                end
                else if (side_fail)
                begin
                    reason_reg <= cbf_pkg::REASON_LARGE;
                end
            end
            S_VOL2:
            begin
                if (mul_done)
                begin
                    vol_reg <= vol_fix;
                    if (vol_small)
                    begin
                        reason_reg <= cbf_pkg::REASON_SMALL;
                    end
                end
            end
            S_SQX:
            begin
                if (mul_done)
                begin
                    n_reg <= mul_product[NW-1:0];
                end
            end
            S_SQY:
            begin
                if (mul_done)
                begin
                    n_reg <= n_reg + mul_product[NW-1:0];
                end
            end
            S_SQZ:
            begin
                if (mul_done)
                begin
                    op_reg  <= n_reg + mul_product[NW-1:0];
                    res_reg <= '0;
                    one_reg <= NW'(1) << (NW - 2);
                end
            end
            S_ROOT:
            begin
                // one result bit per cycle, remainder kept in op_reg
                if (one_reg != '0)
                begin
                    if (root_ge)
                    begin
                        op_reg  <= op_reg - trial;
                        res_reg <= (res_reg >> 1) + one_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    one_reg <= one_reg >> 2;
                end
            end
            S_FALL:
            begin
                if (mul_done)
                begin
                    t_reg <= t_sum;
                end
            end
            S_LHS:
            begin
                if (mul_done)
                begin
                    lhs_reg <= mul_product[LW-1:0];
                end
            end
            S_RHS:
            begin
                if (mul_done && sparse)
                begin
                    reason_reg <= cbf_pkg::REASON_SPARSE;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            keep_reg       <= (reason_reg == cbf_pkg::REASON_KEEP);
            reason_out_reg <= reason_reg;
            ox_lo_reg      <= x_lo_reg;
            ox_hi_reg      <= x_hi_reg;
            oy_lo_reg      <= y_lo_reg;
            oy_hi_reg      <= y_hi_reg;
            oz_lo_reg      <= z_lo_reg;
            oz_hi_reg      <= z_hi_reg;
            total_reg      <= cnt_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign keep          = keep_reg;
    assign reject_reason = reason_out_reg;
    assign box_x_low     = ox_lo_reg;
    assign box_x_high    = ox_hi_reg;
    assign box_y_low     = oy_lo_reg;
    assign box_y_high    = oy_hi_reg;
    assign box_z_low     = oz_lo_reg;
    assign box_z_high    = oz_hi_reg;
    assign point_total   = total_reg;

    a_keep_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (keep_reg == (reason_out_reg == cbf_pkg::REASON_KEEP)))
        else $error("keep flag disagrees with reject reason");

    a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (ox_lo_reg <= ox_hi_reg && oy_lo_reg <= oy_hi_reg
                           && oz_lo_reg <= oz_hi_reg))
        else $error("result box has low above high");

    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_VOL1 || state_reg == S_VOL2 || state_reg == S_SQX
                      || state_reg == S_SQY || state_reg == S_SQZ || state_reg == S_FALL
                      || state_reg == S_CNT || state_reg == S_LHS || state_reg == S_RHS))
        else $error("multiplier finished outside a multiply step");

endmodule

[rtl/core/cluster_box_filter.sv]
// ----------------------------------------------------------------------------
// cluster_box_filter
// Bounding box and keep/reject decision for one point cluster per request
// sequence, with a configuration register port.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while the input is not stalled. The intake
// keeps the running box and count and, on the last point, hands the box to
// a two-entry queue; the evaluator behind it works through the tests with
// one bit-serial multiplier and a digit-by-digit square root. A cluster
// rejected on ground or size skips the multiplier and the square root. The
// input stalls only while both queue entries hold clusters still waiting,
// so clusters whose points take longer to arrive than the evaluation of the
// cluster before them stream without a stall. The result sits in an output
// register and does not hold up evaluation of the next queued cluster until
// it is needed.
// ----------------------------------------------------------------------------
module cluster_box_filter #(
    parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cbf_pkg::CFG_DATA_W-1:0]   cfg_data,
    // points
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [COORD_BITS-1:0]     px,
    input  logic signed [COORD_BITS-1:0]     py,
    input  logic signed [COORD_BITS-1:0]     pz,
    input  logic                             last_point,
    // results
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             keep,
    output logic [cbf_pkg::REASON_W-1:0]     reject_reason,
    output logic signed [COORD_BITS-1:0]     box_x_low,
    output logic signed [COORD_BITS-1:0]     box_x_high,
    output logic signed [COORD_BITS-1:0]     box_y_low,
    output logic signed [COORD_BITS-1:0]     box_y_high,
    output logic signed [COORD_BITS-1:0]     box_z_low,
    output logic signed [COORD_BITS-1:0]     box_z_high,
    output logic [cbf_pkg::COUNT_W-1:0]      point_total
);

    localparam int REC_W = 6 * COORD_BITS + cbf_pkg::COUNT_W;

    logic [15:0]                    ground_reg;
    logic [cbf_pkg::SIDE_W-1:0]     max_side_reg;
    logic [cbf_pkg::VOL_W-1:0]      min_vol_reg;
    logic [cbf_pkg::DENS_W-1:0]     min_dens_reg;
    logic [15:0]                    falloff_reg;

    logic                           push, pop;
    logic [REC_W-1:0]               push_data, pop_data;
    cbf_pkg::q_status_t             q_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ground_reg   <= cbf_pkg::RST_GROUND;
            max_side_reg <= cbf_pkg::RST_MAX_SIDE;
            min_vol_reg  <= cbf_pkg::RST_MIN_VOL;
            min_dens_reg <= cbf_pkg::RST_MIN_DENS;
            falloff_reg  <= cbf_pkg::RST_FALLOFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                cbf_pkg::CFG_GROUND:   ground_reg   <= cfg_data[15:0];
                cbf_pkg::CFG_MAX_SIDE: max_side_reg <= cfg_data[cbf_pkg::SIDE_W-1:0];
                cbf_pkg::CFG_MIN_VOL:  min_vol_reg  <= cfg_data[cbf_pkg::VOL_W-1:0];
                cbf_pkg::CFG_MIN_DENS: min_dens_reg <= cfg_data[cbf_pkg::DENS_W-1:0];
                cbf_pkg::CFG_FALLOFF:  falloff_reg  <= cfg_data[15:0];
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    cbf_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .px         (px),
        .py         (py),
        .pz         (pz),
        .last_point (last_point),
        .q_status   (q_status),
        .push       (push),
        .push_data  (push_data)
    );

    cbf_queue #(
        .W (REC_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    cbf_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .q_status            (q_status),
        .pop_data            (pop_data),
        .pop                 (pop),
        .ground_clearance_cm (ground_reg),
        .max_side_cm         (max_side_reg),
        .min_volume_cm3      (min_vol_reg),
        .min_density_q8      (min_dens_reg),
        .density_falloff_q16 (falloff_reg),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .keep                (keep),
        .reject_reason       (reject_reason),
        .box_x_low           (box_x_low),
        .box_x_high          (box_x_high),
        .box_y_low           (box_y_low),
        .box_y_high          (box_y_high),
        .box_z_low           (box_z_low),
        .box_z_high          (box_z_high),
        .point_total         (point_total)
    );

endmodule
